### rtl/core/vse_pkg.sv
// Shared types and constants for the vector similarity engine.
// Holds the result mode codes, datapath widths and the shift-subtract unit structs.
// No dependencies.
package vse_pkg;

    localparam int ELEM_W     = 16;
    localparam int DIFF_W     = ELEM_W + 1;
    localparam int ACC_W      = 48;
    localparam int RES_W      = 32;
    localparam int OPND_W     = 32;
    localparam int PROD_W     = 2 * OPND_W;
    localparam int SD_W       = 64;
    localparam int QUOT_W     = 34;
    localparam int ROOT_W     = 31;
    localparam int CNT_W      = 6;
    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS  = 34;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

    typedef enum logic [1:0] {
        MODE_DOT  = 2'd0,
        MODE_DIST = 2'd1,
        MODE_COS  = 2'd2,
        MODE_NORM = 2'd3
    } vse_mode_t;

    // Command to the shift-subtract unit: square root or long division.
    typedef struct packed {
        logic            start;
        logic            is_div;
        logic [SD_W-1:0] src;
        logic [SD_W-1:0] rem_init;
        logic [SD_W-1:0] divisor;
    } vse_sd_cmd_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [QUOT_W-1:0] quot;
        logic [SD_W-1:0]   rem;
    } vse_sd_res_t;

endpackage

### rtl/core/vse_mult.sv
// Shared signed multiplier with a registered product.
// Depends on vse_pkg for operand and product widths.
module vse_mult
(
    input  logic                                clk,
    input  logic signed [vse_pkg::OPND_W-1:0]   op_a,
    input  logic signed [vse_pkg::OPND_W-1:0]   op_b,
    output logic signed [vse_pkg::PROD_W-1:0]   prod
);

    logic signed [vse_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

### rtl/core/vse_sqdiv.sv
// Iterative shift-subtract unit: restoring square root (two bits a step)
// or restoring long division (one bit a step). Depends on vse_pkg.
module vse_sqdiv
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  vse_pkg::vse_sd_cmd_t cmd,
    output vse_pkg::vse_sd_res_t res
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic                          is_div_reg, is_div_next;
    logic [vse_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [vse_pkg::SD_W-1:0]      src_reg, src_next;
    logic [vse_pkg::SD_W-1:0]      rem_reg, rem_next;
    logic [vse_pkg::SD_W-1:0]      div_reg, div_next;
    logic [vse_pkg::QUOT_W-1:0]    qr_reg, qr_next;

    logic [vse_pkg::SD_W-1:0]      shifted;
    logic [vse_pkg::SD_W-1:0]      trial;
    logic [vse_pkg::SD_W:0]        diff;
    logic                          fits;

    // The trial subtrahend is the divisor, or 4*root+1 for the square root.
    always_comb
    begin
        if (is_div_reg)
        begin
            shifted = {rem_reg[vse_pkg::SD_W-2:0], src_reg[vse_pkg::SD_W-1]};
            trial   = div_reg;
        end
        else
        begin
            shifted = {rem_reg[vse_pkg::SD_W-3:0], src_reg[vse_pkg::SD_W-1 -: 2]};
            trial   = {{(vse_pkg::SD_W-vse_pkg::QUOT_W-2){1'b0}}, qr_reg, 2'b01};
        end
        diff = {1'b0, shifted} - {1'b0, trial};
        fits = !diff[vse_pkg::SD_W];
    end

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        is_div_next = is_div_reg;
        cnt_next    = cnt_reg;
        src_next    = src_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        qr_next     = qr_reg;
        if (cmd.start)
        begin
            busy_next   = 1'b1;
            is_div_next = cmd.is_div;
            cnt_next    = cmd.is_div ? vse_pkg::CNT_W'(vse_pkg::DIV_STEPS)
                                     : vse_pkg::CNT_W'(vse_pkg::SQRT_STEPS);
            src_next    = cmd.src;
            rem_next    = cmd.rem_init;
            div_next    = cmd.divisor;
            qr_next     = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[vse_pkg::SD_W-1:0] : shifted;
            qr_next  = {qr_reg[vse_pkg::QUOT_W-2:0], fits};
            src_next = is_div_reg ? {src_reg[vse_pkg::SD_W-2:0], 1'b0}
                                  : {src_reg[vse_pkg::SD_W-3:0], 2'b00};
            cnt_next = cnt_reg - vse_pkg::CNT_W'(1);
            if (cnt_reg == vse_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_div_reg <= is_div_next;
        src_reg    <= src_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        qr_reg     <= qr_next;
    end

    assign res.busy = busy_reg;
    assign res.done = done_reg;
    assign res.quot = qr_reg;
    assign res.rem  = rem_reg;

endmodule

### rtl/core/vector_similarity_engine_unit.sv
// Top level of the vector similarity engine: sequencer, accumulators, result formatting.
// Depends on vse_pkg, vse_mult (shared multiplier) and vse_sqdiv (shift-subtract unit).
//
// Usage:
// Element pairs (elem_a, elem_b, signed Q3.12) enter on the input channel, one pair per
// item, with last_elem set on the final pair of the vectors. The block keeps running
// sums of a*b, a*a, b*b and (a-b)^2, each saturating at 48 bits. The final pair is
// accumulated too, and then one result item leaves on the output channel: result_value
// in signed Q15.16, chosen by result_mode (dot product, Euclidean distance, cosine
// similarity, norm of the first vector), with saturated and zero_norm flags. The sums
// are cleared once the result item is placed in the output register.
// result_mode is written through the cfg channel, which is always ready.
// The four products of a pair go through one multiplier, so in_ready stays low after a
// pair is accepted until all four are accumulated; a new pair is not taken before the
// last one is through. Distance and norm take a 31-step square root in the shift-subtract
// unit; cosine with nonzero norms takes two square roots, one product and a 34-step
// division. in_ready is low while a pair or a finish run is in progress.
// The result waits in an output register; the next vector's pairs are accepted while
// it waits. If a new result is ready before the old one was taken, the sequencer
// holds it until out_ready frees the register.
// Reset clears the sums, the mode (dot product) and the output valid.
module vector_similarity_engine_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [vse_pkg::ELEM_W-1:0]   elem_a,
    input  logic signed [vse_pkg::ELEM_W-1:0]   elem_b,
    input  logic                                last_elem,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [vse_pkg::RES_W-1:0]    result_value,
    output logic                                saturated,
    output logic                                zero_norm
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_MAC       = 9'b000000010,
        S_FIN       = 9'b000000100,
        S_ROOT      = 9'b000001000,
        S_ROOT_WAIT = 9'b000010000,
        S_PROD      = 9'b000100000,
        S_DIV       = 9'b001000000,
        S_DIV_WAIT  = 9'b010000000,
        S_OUT       = 9'b100000000
    } state_t;

    localparam int SUM_W = vse_pkg::ACC_W + 2;
    localparam int DOT_W = vse_pkg::ACC_W + 1;

    state_t                               state_reg, state_next;
    logic [2:0]                           step_reg, step_next;
    logic signed [vse_pkg::ELEM_W-1:0]    a_reg, a_next;
    logic signed [vse_pkg::ELEM_W-1:0]    b_reg, b_next;
    logic                                 last_reg, last_next;
    vse_pkg::vse_mode_t                   mode_reg;
    logic signed [vse_pkg::ACC_W-1:0]     sum_prod_reg, sum_prod_next;
    logic signed [vse_pkg::ACC_W-1:0]     sum_sqa_reg, sum_sqa_next;
    logic signed [vse_pkg::ACC_W-1:0]     sum_sqb_reg, sum_sqb_next;
    logic signed [vse_pkg::ACC_W-1:0]     sum_sqd_reg, sum_sqd_next;
    logic                                 pass_reg, pass_next;
    logic [vse_pkg::ROOT_W-1:0]           na_reg, na_next;
    logic signed [vse_pkg::RES_W-1:0]     res_val_reg, res_val_next;
    logic                                 res_sat_reg, res_sat_next;
    logic                                 res_zero_reg, res_zero_next;
    logic                                 out_valid_reg, out_valid_next;
    logic signed [vse_pkg::RES_W-1:0]     result_value_reg, result_value_next;
    logic                                 saturated_reg, saturated_next;
    logic                                 zero_norm_reg, zero_norm_next;

    logic signed [vse_pkg::DIFF_W-1:0]    diff_ab;
    logic signed [vse_pkg::OPND_W-1:0]    mul_a, mul_b;
    logic signed [vse_pkg::PROD_W-1:0]    prod;
    vse_pkg::vse_sd_cmd_t                 sd_cmd;
    vse_pkg::vse_sd_res_t                 sd_res;

    logic signed [vse_pkg::ACC_W-1:0]     acc_in;
    logic signed [SUM_W-1:0]              acc_wide;
    logic signed [vse_pkg::ACC_W-1:0]     acc_sat;
    logic signed [DOT_W-1:0]              dot_wide;
    logic signed [DOT_W-9:0]              dot_q16;
    logic [61:0]                          root_v;
    logic [vse_pkg::ROOT_W-1:0]           root;
    logic [vse_pkg::ACC_W-1:0]            mag;
    logic                                 quot_big;
    logic [vse_pkg::QUOT_W:0]             q_plus;
    logic [vse_pkg::QUOT_W-1:0]           q_rnd;
    logic                                 out_load;

    vse_mult u_mult
    (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    vse_sqdiv u_sqdiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (sd_cmd),
        .res   (sd_res)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign diff_ab   = {a_reg[vse_pkg::ELEM_W-1], a_reg} - {b_reg[vse_pkg::ELEM_W-1], b_reg};
    assign root      = sd_res.quot[vse_pkg::ROOT_W-1:0];
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    // Multiplier operands: the four element products, then the norm product for cosine.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_MAC)
        begin
            case (step_reg)
                3'd0:
                begin
                    mul_a = vse_pkg::OPND_W'(a_reg);
                    mul_b = vse_pkg::OPND_W'(b_reg);
                end
                3'd1:
                begin
                    mul_a = vse_pkg::OPND_W'(a_reg);
                    mul_b = vse_pkg::OPND_W'(a_reg);
                end
                3'd2:
                begin
                    mul_a = vse_pkg::OPND_W'(b_reg);
                    mul_b = vse_pkg::OPND_W'(b_reg);
                end
                3'd3:
                begin
                    mul_a = vse_pkg::OPND_W'(diff_ab);
                    mul_b = vse_pkg::OPND_W'(diff_ab);
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
        else if (state_reg == S_PROD)
        begin
            mul_a = {1'b0, na_reg};
            mul_b = {1'b0, root};
        end
    end

    // One saturating adder serves all four sums; the product of the
    // previous step lands in the sum it belongs to.
    always_comb
    begin
        case (step_reg)
            3'd1:    acc_in = sum_prod_reg;
            3'd2:    acc_in = sum_sqa_reg;
            3'd3:    acc_in = sum_sqb_reg;
            default: acc_in = sum_sqd_reg;
        endcase
        acc_wide = SUM_W'(acc_in) + prod[SUM_W-1:0];
        if (acc_wide[SUM_W-1 -: 3] == 3'b000 || acc_wide[SUM_W-1 -: 3] == 3'b111)
        begin
            acc_sat = acc_wide[vse_pkg::ACC_W-1:0];
        end
        else if (acc_wide[SUM_W-1])
        begin
            acc_sat = vse_pkg::ACC_MIN;
        end
        else
        begin
            acc_sat = vse_pkg::ACC_MAX;
        end
    end

    // Dot product: Q24 to Q16 with rounding half up.
    assign dot_wide = DOT_W'(sum_prod_reg) + DOT_W'(128);
    assign dot_q16  = dot_wide[DOT_W-1:8];

    // Square root operand: sums shifted up to a Q32 radicand for the norms,
    // by 14 for the cosine denominators.
    always_comb
    begin
        if (mode_reg == vse_pkg::MODE_COS)
        begin
            root_v = pass_reg ? {1'b0, sum_sqb_reg[vse_pkg::ACC_W-2:0], 14'b0}
                              : {1'b0, sum_sqa_reg[vse_pkg::ACC_W-2:0], 14'b0};
        end
        else if (mode_reg == vse_pkg::MODE_DIST)
        begin
            root_v = {7'b0, sum_sqd_reg[vse_pkg::ACC_W-2:0], 8'b0};
        end
        else
        begin
            root_v = {7'b0, sum_sqa_reg[vse_pkg::ACC_W-2:0], 8'b0};
        end
    end

    // Cosine: the magnitude of the dot product over the norm product. The quotient
    // overflows whenever the magnitude reaches eight times the denominator.
    assign mag      = sum_prod_reg[vse_pkg::ACC_W-1] ? (~sum_prod_reg + 1'b1) : sum_prod_reg;
    assign quot_big = {16'b0, mag} >= {prod[60:0], 3'b000};
    assign q_plus   = {1'b0, sd_res.quot} + (vse_pkg::QUOT_W+1)'(1);
    assign q_rnd    = q_plus[vse_pkg::QUOT_W:1];

    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        last_next         = last_reg;
        sum_prod_next     = sum_prod_reg;
        sum_sqa_next      = sum_sqa_reg;
        sum_sqb_next      = sum_sqb_reg;
        sum_sqd_next      = sum_sqd_reg;
        pass_next         = pass_reg;
        na_next           = na_reg;
        res_val_next      = res_val_reg;
        res_sat_next      = res_sat_reg;
        res_zero_next     = res_zero_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        result_value_next = result_value_reg;
        saturated_next    = saturated_reg;
        zero_norm_next    = zero_norm_reg;
        sd_cmd            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    a_next     = elem_a;
                    b_next     = elem_b;
                    last_next  = last_elem;
                    step_next  = '0;
                    state_next = S_MAC;
                end
            end

            S_MAC:
            begin
                case (step_reg)
                    3'd1:    sum_prod_next = acc_sat;
                    3'd2:    sum_sqa_next  = acc_sat;
                    3'd3:    sum_sqb_next  = acc_sat;
                    3'd4:    sum_sqd_next  = acc_sat;
                    default: sum_prod_next = sum_prod_reg;
                endcase
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd4)
                begin
                    state_next = last_reg ? S_FIN : S_IDLE;
                end
            end

            S_FIN:
            begin
                res_sat_next  = 1'b0;
                res_zero_next = 1'b0;
                pass_next     = 1'b0;
                case (mode_reg)
                    vse_pkg::MODE_DOT:
                    begin
                        if (!dot_q16[DOT_W-9] && dot_q16[DOT_W-10:31] != '0)
                        begin
                            res_val_next = vse_pkg::RES_MAX;
                            res_sat_next = 1'b1;
                        end
                        else if (dot_q16[DOT_W-9] && dot_q16[DOT_W-10:31] != '1)
                        begin
                            res_val_next = vse_pkg::RES_MIN;
                            res_sat_next = 1'b1;
                        end
                        else
                        begin
                            res_val_next = dot_q16[vse_pkg::RES_W-1:0];
                        end
                        state_next = S_OUT;
                    end
                    vse_pkg::MODE_COS:
                    begin
                        if (sum_sqa_reg == '0 || sum_sqb_reg == '0)
                        begin
                            res_val_next  = '0;
                            res_zero_next = 1'b1;
                            state_next    = S_OUT;
                        end
                        else
                        begin
                            state_next = S_ROOT;
                        end
                    end
                    default:
                    begin
                        state_next = S_ROOT;
                    end
                endcase
            end

            S_ROOT:
            begin
                sd_cmd.start    = 1'b1;
                sd_cmd.is_div   = 1'b0;
                sd_cmd.src      = {root_v, 2'b00};
                sd_cmd.rem_init = '0;
                sd_cmd.divisor  = '0;
                state_next      = S_ROOT_WAIT;
            end

            S_ROOT_WAIT:
            begin
                if (sd_res.done)
                begin
                    if (mode_reg == vse_pkg::MODE_COS)
                    begin
                        if (!pass_reg)
                        begin
                            na_next    = root;
                            pass_next  = 1'b1;
                            state_next = S_ROOT;
                        end
                        else
                        begin
                            state_next = S_PROD;
                        end
                    end
                    else
                    begin
                        // Round to nearest: bump when the remainder exceeds the root.
                        if (sd_res.rem > vse_pkg::SD_W'(root))
                        begin
                            res_val_next = {1'b0, root} + vse_pkg::RES_W'(1);
                        end
                        else
                        begin
                            res_val_next = {1'b0, root};
                        end
                        state_next = S_OUT;
                    end
                end
            end

            S_PROD:
            begin
                state_next = S_DIV;
            end

            S_DIV:
            begin
                if (quot_big)
                begin
                    res_val_next = sum_prod_reg[vse_pkg::ACC_W-1] ? vse_pkg::RES_MIN
                                                                 : vse_pkg::RES_MAX;
                    res_sat_next = 1'b1;
                    state_next   = S_OUT;
                end
                else
                begin
                    sd_cmd.start    = 1'b1;
                    sd_cmd.is_div   = 1'b1;
                    sd_cmd.src      = {mag[2:0], {(vse_pkg::SD_W-3){1'b0}}};
                    sd_cmd.rem_init = vse_pkg::SD_W'(mag[vse_pkg::ACC_W-1:3]);
                    sd_cmd.divisor  = prod;
                    state_next      = S_DIV_WAIT;
                end
            end

            S_DIV_WAIT:
            begin
                if (sd_res.done)
                begin
                    if (!sum_prod_reg[vse_pkg::ACC_W-1])
                    begin
                        if (q_rnd[vse_pkg::QUOT_W-1:31] != '0)
                        begin
                            res_val_next = vse_pkg::RES_MAX;
                            res_sat_next = 1'b1;
                        end
                        else
                        begin
                            res_val_next = q_rnd[vse_pkg::RES_W-1:0];
                        end
                    end
                    else
                    begin
                        if (q_rnd > vse_pkg::QUOT_W'(34'h0_8000_0000))
                        begin
                            res_val_next = vse_pkg::RES_MIN;
                            res_sat_next = 1'b1;
                        end
                        else
                        begin
                            res_val_next = ~q_rnd[vse_pkg::RES_W-1:0] + vse_pkg::RES_W'(1);
                        end
                    end
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next    = 1'b1;
                    result_value_next = res_val_reg;
                    saturated_next    = res_sat_reg;
                    zero_norm_next    = res_zero_reg;
                    sum_prod_next     = '0;
                    sum_sqa_next      = '0;
                    sum_sqb_next      = '0;
                    sum_sqd_next      = '0;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            mode_reg      <= vse_pkg::MODE_DOT;
            sum_prod_reg  <= '0;
            sum_sqa_reg   <= '0;
            sum_sqb_reg   <= '0;
            sum_sqd_reg   <= '0;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            sum_prod_reg  <= sum_prod_next;
            sum_sqa_reg   <= sum_sqa_next;
            sum_sqb_reg   <= sum_sqb_next;
            sum_sqd_reg   <= sum_sqd_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= vse_pkg::vse_mode_t'(cfg_data);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg            <= a_next;
        b_reg            <= b_next;
        last_reg         <= last_next;
        na_reg           <= na_next;
        res_val_reg      <= res_val_next;
        res_sat_reg      <= res_sat_next;
        res_zero_reg     <= res_zero_next;
        result_value_reg <= result_value_next;
        saturated_reg    <= saturated_next;
        zero_norm_reg    <= zero_norm_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign saturated    = saturated_reg;
    assign zero_norm    = zero_norm_reg;

    // The shift-subtract unit is never left running while a new pair can come in.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !sd_res.busy)
        else $error("shift-subtract unit busy while accepting pairs");

    // A zero-norm cosine result is exactly zero and never flagged as clipped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_norm) |-> (!saturated && result_value == '0))
        else $error("zero-norm result carries a value or a saturation flag");

    // Handing a result to the output register starts the next vector from empty sums.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (sum_prod_reg == '0 && sum_sqa_reg == '0 &&
                      sum_sqb_reg == '0 && sum_sqd_reg == '0))
        else $error("sums not cleared after a result");

endmodule
